/* sv/csm_pkg.sv */
// ----------------------------------------------------------------------------
// csm_pkg: shared types and constants for the suffix match unit
// Widths, command codes, the queue entry and the case-folding function.
// ----------------------------------------------------------------------------
package csm_pkg;

  localparam int MaxPatterns = 16;
  localparam int MaxPatLen   = 32;
  localparam int PatW        = $clog2(MaxPatterns);
  localparam int OffW        = $clog2(MaxPatLen);
  localparam int LenW        = $clog2(MaxPatLen + 1);
  localparam int CharW       = 8;
  localparam int CountW      = 5;
  localparam int QueueDepth  = 4;
  localparam int QPtrW       = $clog2(QueueDepth);
  localparam int QCntW       = $clog2(QueueDepth + 1);

  // opcode as it arrives on the stream
  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_LEN  = 2'd1,
    OP_SUBJ = 2'd2,
    OP_NONE = 2'd3
  } opcode_e;

  // work kinds handed to the back end
  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_LEN  = 2'd1,
    CMD_SUBJ = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e             kind;
    logic [PatW-1:0]       pidx;
    logic [OffW-1:0]       coff;
    logic [LenW-1:0]       plen;   // already clamped
    logic [CharW-1:0]      cval;   // already folded to lower case
    logic                  last;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // ASCII upper case to lower case, other bytes pass unchanged
  function automatic logic [CharW-1:0] fold_case(input logic [CharW-1:0] c);
    logic [CharW-1:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

/* sv/csm_front.sv */
// ----------------------------------------------------------------------------
// csm_front: input stage
// Takes stream items, drops unused opcodes, folds case, clamps lengths and
// holds one command until the queue takes it.
// ----------------------------------------------------------------------------
module csm_front import csm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [23:0]         s_axis_tdata,  // pattern_index, char_offset, pattern_length, char_value
  input  logic [1:0]          s_axis_tuser,  // opcode
  input  logic                s_axis_tlast,  // final_char
  input  q_stat_t             q_stat_i,
  output logic                push_o,
  output cmd_t                cmd_o
);

  logic    v_q, v_d;
  cmd_t    cmd_q, cmd_d;
  logic    accept;
  logic    keep;
  opcode_e op;
  logic [LenW-1:0] plen_raw;

  assign s_axis_tready = !v_q || !q_stat_i.full;
  assign push_o        = v_q && !q_stat_i.full;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign op            = opcode_e'(s_axis_tuser);
  assign plen_raw      = s_axis_tdata[14:9];

  // classify the incoming item
  always_comb begin
    keep       = 1'b1;
    cmd_d      = cmd_q;
    cmd_d.pidx = s_axis_tdata[PatW-1:0];
    cmd_d.coff = s_axis_tdata[8:4];
    cmd_d.cval = fold_case(s_axis_tdata[22:15]);
    cmd_d.last = s_axis_tlast;
    cmd_d.plen = (plen_raw > LenW'(MaxPatLen)) ? LenW'(MaxPatLen) : plen_raw;
    unique case (op)
      OP_LOAD: cmd_d.kind = CMD_LOAD;
      OP_LEN:  cmd_d.kind = CMD_LEN;
      OP_SUBJ: cmd_d.kind = CMD_SUBJ;
      OP_NONE: begin
        cmd_d.kind = CMD_SUBJ;
        keep       = 1'b0;
      end
      default: begin
        cmd_d.kind = CMD_SUBJ;
        keep       = 1'b0;
      end
    endcase
  end

  // holding register valid
  always_comb begin
    v_d = v_q && !push_o;
    if (accept && keep) begin
      v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && keep) begin
      cmd_q <= cmd_d;
    end
  end

  assign cmd_o = cmd_q;

endmodule

/* sv/csm_fifo.sv */
// ----------------------------------------------------------------------------
// csm_fifo: command queue
// Short first-in first-out queue between the front and back ends.
// ----------------------------------------------------------------------------
module csm_fifo import csm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  cmd_t    cmd_i,
  input  logic    pop_i,
  output cmd_t    head_o,
  output q_stat_t stat_o
);

  cmd_t              mem_q [QueueDepth];
  logic [QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]  cnt_q, cnt_d;

  assign stat_o.full  = (cnt_q == QCntW'(QueueDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

/* sv/csm_back.sv */
// ----------------------------------------------------------------------------
// csm_back: pattern tables and comparison pipeline
// Stage one writes the tables or reads one character per pattern; stage two
// compares, updates the active mask and latches, and loads the result.
// ----------------------------------------------------------------------------
module csm_back import csm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              head_i,
  input  q_stat_t           q_stat_i,
  output logic              pop_o,
  input  logic [CountW-1:0] count_i,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [7:0]        m_axis_tdata   // suffix_found
);

  // per-pattern lengths and read registers (no reset)
  logic [LenW-1:0]  len_q   [MaxPatterns];
  logic [CharW-1:0] rd_q    [MaxPatterns];

  logic [LenW-1:0]        pos_q;
  logic                   s2_v_q, s2_final_q;
  logic [CharW-1:0]       s2_cval_q;
  logic [MaxPatterns-1:0] s2_inr_q, s2_last_q;
  logic [MaxPatterns-1:0] inr, lastc;
  logic [OffW-1:0]        addr [MaxPatterns];

  logic [MaxPatterns-1:0] mask_q, mask_d;
  logic                   match_q, match_d, dead_q, dead_d;
  logic                   out_v_q, out_v_d, out_d_q, out_d_d;
  logic [MaxPatterns-1:0] m_vec, surv, clr;
  logic                   stall, s2_adv, fire, pop_subj, match_new;

  // pipeline flow
  assign stall    = s2_v_q && s2_final_q && out_v_q && !m_axis_tready;
  assign s2_adv   = !s2_v_q || !stall;
  assign pop_o    = !q_stat_i.empty && s2_adv;
  assign pop_subj = pop_o && (head_i.kind == CMD_SUBJ);
  assign fire     = s2_v_q && !stall;

  // stage one: per pattern table access, one small character memory each
  for (genvar p = 0; p < MaxPatterns; p++) begin : g_pat
    logic [CharW-1:0] chars_q [MaxPatLen];
    logic [LenW-1:0]  diff;
    assign diff     = len_q[p] - pos_q - LenW'(1);
    assign addr[p]  = diff[OffW-1:0];
    assign inr[p]   = pos_q < len_q[p];
    assign lastc[p] = (pos_q + LenW'(1)) == len_q[p];

    always_ff @(posedge clk_i) begin
      if (pop_o && head_i.kind == CMD_LOAD && head_i.pidx == PatW'(p)) begin
        chars_q[head_i.coff] <= head_i.cval;
      end
      if (pop_o && head_i.kind == CMD_LEN && head_i.pidx == PatW'(p)) begin
        len_q[p] <= head_i.plen;
      end
      if (pop_subj) begin
        rd_q[p] <= chars_q[addr[p]];
      end
    end
  end

  // subject position and stage two control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      s2_v_q <= 1'b0;
    end else begin
      if (pop_subj) begin
        if (head_i.last) begin
          pos_q <= '0;
        end else if (pos_q < LenW'(MaxPatLen)) begin
          pos_q <= pos_q + LenW'(1);
        end
      end
      if (s2_adv) begin
        s2_v_q <= pop_subj;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_subj) begin
      s2_final_q <= head_i.last;
      s2_cval_q  <= head_i.cval;
      s2_inr_q   <= inr;
      s2_last_q  <= lastc;
    end
  end

  // stage two: compare against every pattern in use
  always_comb begin
    for (int p = 0; p < MaxPatterns; p++) begin
      logic en, hit;
      en       = (CountW'(p) < count_i) && mask_q[p];
      hit      = s2_inr_q[p] && (rd_q[p] == s2_cval_q);
      m_vec[p] = en && hit && s2_last_q[p];
      surv[p]  = en && hit && !s2_last_q[p];
      clr[p]   = en && !hit;
    end
  end

  assign match_new = match_q || (!dead_q && (|m_vec));

  always_comb begin
    mask_d  = mask_q;
    match_d = match_q;
    dead_d  = dead_q;
    out_v_d = out_v_q && !m_axis_tready;
    out_d_d = out_d_q;
    if (fire) begin
      if (!match_q && !dead_q) begin
        if (|m_vec) begin
          match_d = 1'b1;
        end else begin
          mask_d = mask_q & ~clr;
          if (!(|surv)) begin
            dead_d = 1'b1;
          end
        end
      end
      if (s2_final_q) begin
        out_v_d = 1'b1;
        out_d_d = match_new;
        mask_d  = '1;
        match_d = 1'b0;
        dead_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q  <= '1;
      match_q <= 1'b0;
      dead_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      mask_q  <= mask_d;
      match_q <= match_d;
      dead_q  <= dead_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_d_q <= out_d_d;
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {7'b0, out_d_q};

endmodule

/* sv/case_insensitive_multi_suffix_match_unit.sv */
// Path: the result of a string follows its last byte (final_char), once it is
// accepted, through the input register, the queue, the table read and the compare.
// Throughput: one item per cycle, set by the single table read per pattern
// in stage one; a stalled result holds stage two and, through the queue, input.
// Reset: asynchronous, active low; clears control state and sets the pattern
// count to 1. Pattern tables are undefined until written.
// ----------------------------------------------------------------------------
// case_insensitive_multi_suffix_match_unit: top level
// Multi-pattern case-insensitive suffix matcher with an APB register port.
// ----------------------------------------------------------------------------
module case_insensitive_multi_suffix_match_unit import csm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [3:0] pattern_index, [8:4] char_offset,
                                     // [14:9] pattern_length, [22:15] char_value
  input  logic [1:0]  s_axis_tuser,  // [1:0] opcode
  input  logic        s_axis_tlast,  // final_char
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata   // [0] suffix_found
);

  logic [CountW-1:0] count_q;
  logic              cfg_wr;
  logic              fq_push;
  cmd_t              fq_cmd, q_head;
  q_stat_t           q_stat;
  logic              bk_pop;

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {27'b0, count_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CountW'(1);
    end else if (cfg_wr) begin
      count_q <= pwdata[CountW-1:0];
    end
  end

  csm_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .q_stat_i      (q_stat),
    .push_o        (fq_push),
    .cmd_o         (fq_cmd)
  );

  csm_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fq_push),
    .cmd_i  (fq_cmd),
    .pop_i  (bk_pop),
    .head_o (q_head),
    .stat_o (q_stat)
  );

  csm_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (q_head),
    .q_stat_i      (q_stat),
    .pop_o         (bk_pop),
    .count_i       (count_q),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // queue never overflows or underflows
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fq_push |-> !q_stat.full) else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_pop |-> !q_stat.empty) else $error("pop from empty queue");

  a_pop_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bk_pop && !fq_push) |=> !q_stat.full) else $error("queue full after pop");

endmodule
